### rtl/srlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlr_pkg
// Shared types and character constants of the serial receive line router.
// ----------------------------------------------------------------------------
package srlr_pkg;

	localparam int BYTE_W = 8;
	localparam int MODE_W = 3;
	localparam int CMD_W  = 1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [1:0]        dest_t;

	// Destination codes of a result item.
	localparam dest_t DEST_FRAME  = 2'd0;
	localparam dest_t DEST_LINE   = 2'd1;
	localparam dest_t DEST_BINARY = 2'd2;

	// Input commands.
	localparam logic [CMD_W-1:0] CMD_BYTE  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

	// Characters that steer the line editor.
	localparam byte_t CH_CR    = 8'h0d;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_HIGH  = 8'h80;

endpackage

### rtl/serial_rx_line_router.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_rx_line_router
// Routes received serial bytes to the frame processor, the command line or
// the binary path, and assembles printable text into a line buffer memory.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                        Contents
// s_*       in   s_tvalid s_tready s_tdata      rx_byte in tdata, command in tuser
//                s_tuser
// m_*       out  m_tvalid m_tready m_tdata      out_byte and line_count in tdata,
//                m_tuser m_tlast                destination in tuser, last in tlast
// cfg_*     in   cfg_we cfg_wdata               mode word, written when cfg_we high
//
// An item is taken in while the sequencer is idle and produces its frame or
// binary result in the frame state; a clear command gives no result. A
// carriage return that dispatches a non-empty line then offers each stored
// byte, read from the line memory, in the line state. A stall on the master
// side holds the sequencer in place; the pending item and the memory read
// pointer keep their values. Reset clears the fill count, the mode word and
// all handshake state; the line memory needs no clearing because only entries
// below the fill count are ever read.
//
// ----------------------------------------------------------------------------
module serial_rx_line_router #(
	parameter int MAX_LINE = 44
) (
	input  logic                        clk,
	input  logic                        arst_n,

	// Slave side: tdata = rx_byte[7:0]; tuser = command[0].
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [srlr_pkg::BYTE_W-1:0] s_tdata,
	input  logic [srlr_pkg::CMD_W-1:0]  s_tuser,

	// Master side: tdata = out_byte[7:0], line_count above it, zero padded;
	// tuser = destination[1:0]; tlast = last.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [((srlr_pkg::BYTE_W + $clog2(MAX_LINE + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast,

	// Configuration: mode word.
	input  logic                        cfg_we,
	input  logic [srlr_pkg::MODE_W-1:0] cfg_wdata
);

	// Width of a character count (0..MAX_LINE) and of a memory address.
	localparam int CW  = $clog2(MAX_LINE + 1);
	localparam int AW  = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
	localparam int TDW = ((srlr_pkg::BYTE_W + CW + 7) / 8) * 8;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FRAME = 2'd1;
	localparam logic [1:0] ST_LINE  = 2'd2;

	logic [1:0]                 state_q;

	// Pending input item.
	logic [srlr_pkg::CMD_W-1:0] cmd_q;
	srlr_pkg::byte_t            byte_q;

	// Configuration and line bookkeeping.
	srlr_pkg::mode_t            mode_q;
	logic [CW-1:0]              fill_q;   // characters held in the line memory
	logic [CW-1:0]              len_q;    // length of the line being dispatched
	logic [AW-1:0]              idx_q;    // line byte presently offered

	// Line memory, one write and one registered read port.
	srlr_pkg::byte_t            line_mem [MAX_LINE];
	srlr_pkg::byte_t            rd_data_q;
	logic [AW-1:0]              rd_addr;
	logic                       mem_we;

	// Output register.
	logic                       ovalid_q;
	srlr_pkg::dest_t            odest_q;
	srlr_pkg::byte_t            obyte_q;
	logic [CW-1:0]              ocnt_q;
	logic                       olast_q;

	logic                       out_free;
	logic                       text_mode;
	logic                       printable;
	logic                       line_last;
	logic                       line_adv;

	assign out_free  = !ovalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);

	// Text mode when mode bits 0 and 1 are both clear, or when bit 2 is set.
	assign text_mode = (mode_q[1:0] == 2'b00) || mode_q[2];
	assign printable = (byte_q >= srlr_pkg::CH_SPACE) && (byte_q < srlr_pkg::CH_HIGH);

	// The byte now in rd_data_q is the final one of the line.
	assign line_last = ((CW'(idx_q) + CW'(1)) == len_q);
	assign line_adv  = (state_q == ST_LINE) && out_free && !line_last;

	// The read address runs one entry ahead of the offered byte as soon as the
	// present one is taken, so that a byte leaves the memory every cycle while the master side does not stall.
	always_comb begin
		if (state_q == ST_LINE) begin
			rd_addr = line_adv ? (idx_q + AW'(1)) : idx_q;
		end else begin
			rd_addr = '0;
		end
	end

	// In text mode with mode bit 2 clear, a printable byte is appended while there is still room for it.
	assign mem_we = (state_q == ST_FRAME) && out_free && (cmd_q == srlr_pkg::CMD_BYTE)
		&& text_mode && !mode_q[2] && (byte_q != srlr_pkg::CH_CR) && printable
		&& (fill_q < CW'(MAX_LINE));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[fill_q[AW-1:0]] <= byte_q;
		end
		rd_data_q <= line_mem[rd_addr];
	end

	// Payload registers of the pending item.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_q <= s_tdata;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Sequencer, fill count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= srlr_pkg::CMD_BYTE;
			fill_q   <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
			odest_q  <= srlr_pkg::DEST_FRAME;
			obyte_q  <= '0;
			ocnt_q   <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						state_q <= ST_FRAME;
					end
				end

				ST_FRAME: begin
					if (cmd_q == srlr_pkg::CMD_CLEAR) begin
						// A clear command empties the line and gives no result.
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						ovalid_q <= 1'b1;
						obyte_q  <= byte_q;
						ocnt_q   <= '0;
						olast_q  <= 1'b1;
						state_q  <= ST_IDLE;
						if (!text_mode) begin
							odest_q <= srlr_pkg::DEST_BINARY;
						end else begin
							odest_q <= srlr_pkg::DEST_FRAME;
							if (mode_q[2]) begin
								fill_q <= '0;
							end else if (byte_q == srlr_pkg::CH_CR) begin
								// A non-empty line follows the frame byte.
								fill_q <= '0;
								if (fill_q != '0) begin
									olast_q <= 1'b0;
									len_q   <= fill_q;
									idx_q   <= '0;
									state_q <= ST_LINE;
								end
							end else if (!printable) begin
								fill_q <= '0;
							end else if (fill_q < CW'(MAX_LINE)) begin
								fill_q <= fill_q + CW'(1);
							end else begin
								// Overlong line: the whole line is discarded.
								fill_q <= '0;
							end
						end
					end
				end

				ST_LINE: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						odest_q  <= srlr_pkg::DEST_LINE;
						obyte_q  <= rd_data_q;
						ocnt_q   <= len_q;
						olast_q  <= line_last;
						if (line_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = TDW'({ocnt_q, obyte_q});
	assign m_tuser  = odest_q;
	assign m_tlast  = olast_q;

endmodule
